[design/pwi_pkg.sv]
package pwi_pkg;

	// Field widths
	localparam int TW  = 40;
	localparam int VW  = 32;
	localparam int RW  = 64;
	localparam int EW  = TW + VW;

	// Shared multiply / divide unit widths
	localparam int MAW = VW + 1;
	localparam int MBW = TW + 1;
	localparam int PW  = MAW + MBW;
	localparam int DRW = MBW + 1;
	localparam int CNTW = 7;
	localparam logic [CNTW-1:0] MUL_LAST = CNTW'(MBW - 1);
	localparam logic [CNTW-1:0] DIV_LAST = CNTW'(PW - 1);

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_EVAL  = 2'd1,
		OP_INTEG = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		RS_ZERO,
		RS_LAST,
		RS_NEXT
	} rsel_t;

	typedef enum logic [1:0] {
		VS_RDATA,
		VS_PREV,
		VS_APPLY
	} vsel_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_RD0,
		S_CHK0,
		S_CHKL,
		S_SCAN,
		S_DIFF,
		S_GAP,
		S_MUL,
		S_DIVLD,
		S_DIV,
		S_APPLY,
		S_EVDONE,
		S_ISUM,
		S_IMAG,
		S_IMUL,
		S_ISAT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic  cap_item;
		logic  wr_en;
		logic  rd_en;
		rsel_t rd_sel;
		logic  set_tb;
		logic  idx_clr;
		logic  cap_prev;
		logic  cap_hi;
		logic  calc_diff;
		logic  load_mul;
		logic  step_mul;
		logic  load_div;
		logic  step_div;
		logic  v_load;
		vsel_t v_sel;
		logic  set_err;
		logic  save_va;
		logic  calc_isum;
		logic  calc_sat;
		logic  out_load;
		logic  res_integ;
	} cmd_t;

	typedef struct packed {
		logic t_lt;
		logic idx_last;
		logic gap_bad;
		logic cnt_zero;
	} stat_t;

	function automatic logic [MAW-1:0] mag_a(input logic signed [MAW-1:0] x);
		mag_a = x[MAW-1] ? MAW'(-x) : MAW'(x);
	endfunction

	function automatic logic [MBW-1:0] mag_b(input logic signed [MBW-1:0] x);
		mag_b = x[MBW-1] ? MBW'(-x) : MBW'(x);
	endfunction

endpackage

[design/pwi_in_if.sv]
interface pwi_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [5:0]         point_index;
	logic signed [39:0] time_a;
	logic signed [39:0] time_b;
	logic signed [31:0] volt_in;

	modport source (output valid, opcode, point_index, time_a, time_b, volt_in,
		input ready);
	modport sink (input valid, opcode, point_index, time_a, time_b, volt_in,
		output ready);
endinterface

[design/pwi_out_if.sv]
interface pwi_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] result_value;
	logic               gap_error;
	logic               saturated;

	modport source (output valid, result_value, gap_error, saturated, input ready);
	modport sink (input valid, result_value, gap_error, saturated, output ready);
endinterface

[design/pwi_ram.sv]
module pwi_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[design/pwi_ctrl.sv]
module pwi_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [1:0]     in_opcode,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  pwi_pkg::stat_t stat,
	output pwi_pkg::cmd_t  cmd
);
	import pwi_pkg::*;

	state_t state_q, state_d;
	logic   phase_q, phase_d;
	logic   integ_q, integ_d;
	logic   out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		integ_d = integ_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					phase_d = 1'b0;
					integ_d = (in_opcode == OP_INTEG);
					if (in_opcode == OP_EVAL || in_opcode == OP_INTEG) begin
						state_d = S_RD0;
					end
				end
			end
			S_RD0: state_d = S_CHK0;
			S_CHK0: state_d = stat.t_lt ? S_EVDONE : S_CHKL;
			S_CHKL: state_d = stat.t_lt ? S_SCAN : S_EVDONE;
			S_SCAN: begin
				if (stat.t_lt) begin
					state_d = S_DIFF;
				end else if (stat.idx_last) begin
					state_d = S_EVDONE;
				end
			end
			S_DIFF: state_d = S_GAP;
			S_GAP: state_d = stat.gap_bad ? S_EVDONE : S_MUL;
			S_MUL: if (stat.cnt_zero) state_d = S_DIVLD;
			S_DIVLD: state_d = S_DIV;
			S_DIV: if (stat.cnt_zero) state_d = S_APPLY;
			S_APPLY: state_d = S_EVDONE;
			S_EVDONE: begin
				if (integ_q && !phase_q) begin
					phase_d = 1'b1;
					state_d = S_RD0;
				end else if (integ_q) begin
					state_d = S_ISUM;
				end else begin
					state_d = S_OUT;
				end
			end
			S_ISUM: state_d = S_IMAG;
			S_IMAG: state_d = S_IMUL;
			S_IMUL: if (stat.cnt_zero) state_d = S_ISAT;
			S_ISAT: state_d = S_OUT;
			S_OUT: if (!out_valid_q || out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd = '0;
		cmd.rd_sel = RS_ZERO;
		cmd.v_sel = VS_RDATA;
		cmd.res_integ = integ_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cap_item = 1'b1;
					cmd.wr_en = (in_opcode == OP_WRITE);
				end
			end
			S_RD0: begin
				cmd.rd_en = 1'b1;
				cmd.rd_sel = RS_ZERO;
			end
			S_CHK0: begin
				cmd.cap_prev = 1'b1;
				cmd.idx_clr = 1'b1;
				if (stat.t_lt) begin
					cmd.v_load = 1'b1;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RS_LAST;
				end
			end
			S_CHKL: begin
				if (stat.t_lt) begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RS_NEXT;
				end else begin
					cmd.v_load = 1'b1;
				end
			end
			S_SCAN: begin
				if (stat.t_lt) begin
					cmd.cap_hi = 1'b1;
				end else if (stat.idx_last) begin
					cmd.v_load = 1'b1;
				end else begin
					cmd.cap_prev = 1'b1;
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RS_NEXT;
				end
			end
			S_DIFF: cmd.calc_diff = 1'b1;
			S_GAP: begin
				if (stat.gap_bad) begin
					cmd.v_load = 1'b1;
					cmd.v_sel = VS_PREV;
					cmd.set_err = 1'b1;
				end else begin
					cmd.load_mul = 1'b1;
				end
			end
			S_MUL: cmd.step_mul = 1'b1;
			S_DIVLD: cmd.load_div = 1'b1;
			S_DIV: cmd.step_div = 1'b1;
			S_APPLY: begin
				cmd.v_load = 1'b1;
				cmd.v_sel = VS_APPLY;
			end
			S_EVDONE: begin
				if (integ_q && !phase_q) begin
					cmd.save_va = 1'b1;
					cmd.set_tb = 1'b1;
				end
			end
			S_ISUM: cmd.calc_isum = 1'b1;
			S_IMAG: cmd.load_mul = 1'b1;
			S_IMUL: cmd.step_mul = 1'b1;
			S_ISAT: cmd.calc_sat = 1'b1;
			S_OUT: cmd.out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// State and result slot registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= 1'b0;
			integ_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			integ_q <= integ_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

[design/pwi_dp.sv]
module pwi_dp #(
	parameter int MAX_POINTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pwi_pkg::cmd_t      cmd,
	output pwi_pkg::stat_t     stat,
	input  logic [5:0]         point_index,
	input  logic signed [39:0] time_a,
	input  logic signed [39:0] time_b,
	input  logic signed [31:0] volt_in,
	input  logic               cfg_we,
	input  logic [6:0]         cfg_wdata,
	output logic signed [63:0] result_value,
	output logic               gap_error,
	output logic               saturated
);
	import pwi_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	logic [CW-1:0] n_q;
	logic [31:0]   cfg_ext, n_d;
	logic [AW-1:0] last_idx, idx_q, raddr, waddr;
	logic [31:0]   idx_ext;
	logic          wr_ok;
	logic [EW-1:0] rdata;
	logic signed [TW-1:0] rd_t;
	logic signed [VW-1:0] rd_v;

	logic signed [TW-1:0] ta_q, tb_q, t_q, prev_t_q, t1_q;
	logic signed [VW-1:0] prev_v_q, v1_q, v_q, va_q;
	logic signed [MBW-1:0] gap_q, dt_q;
	logic signed [MAW-1:0] dv_q;
	logic [MAW-1:0] a_q;
	logic [PW-1:0]  p_q;
	logic [DRW-1:0] rem_q, rem_sh, gap_ext;
	logic           rem_ge;
	logic [MAW:0]   mul_hi;
	logic           sign_q;
	logic [CNTW-1:0] cnt_q;
	logic           err_q;
	logic signed [MAW:0] v_apply;
	logic [PW-2:0]  half;
	logic           sat_neg, sat_over;
	logic [RW-1:0]  sat_lo;
	logic signed [RW-1:0] ires_q;
	logic           isat_q;

	// Clamp the point count
	assign cfg_ext = 32'(cfg_wdata);
	always_comb begin
		if (cfg_ext == 32'd0) begin
			n_d = 32'd1;
		end else if (cfg_ext > 32'(MAX_POINTS)) begin
			n_d = 32'(MAX_POINTS);
		end else begin
			n_d = cfg_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= CW'(1);
		end else if (cfg_we) begin
			n_q <= CW'(n_d);
		end
	end

	assign last_idx = AW'(n_q - CW'(1));

	// Breakpoint table
	assign idx_ext = 32'(point_index);
	assign wr_ok = cmd.wr_en && (idx_ext < 32'(MAX_POINTS));
	assign waddr = idx_ext[AW-1:0];

	always_comb begin
		case (cmd.rd_sel)
			RS_ZERO: raddr = '0;
			RS_LAST: raddr = last_idx;
			RS_NEXT: raddr = idx_q + AW'(1);
			default: raddr = '0;
		endcase
	end

	pwi_ram #(.WIDTH(EW), .DEPTH(MAX_POINTS)) u_ram (
		.clk   (clk),
		.we    (wr_ok),
		.waddr (waddr),
		.wdata ({time_a, volt_in}),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_t = rdata[EW-1:VW];
	assign rd_v = rdata[VW-1:0];

	// Status to the controller
	assign stat.t_lt = t_q < rd_t;
	assign stat.idx_last = (idx_q == last_idx);
	assign stat.gap_bad = (gap_q <= 0);
	assign stat.cnt_zero = (cnt_q == '0);

	// Scan index
	always_ff @(posedge clk) begin
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.rd_en && cmd.rd_sel == RS_NEXT) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	// Error flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= 1'b0;
		end else if (cmd.cap_item) begin
			err_q <= 1'b0;
		end else if (cmd.set_err) begin
			err_q <= 1'b1;
		end
	end

	// Multiply step: add the multiplicand on a set low bit, shift right
	assign mul_hi = {1'b0, p_q[PW-1:MBW]} + (p_q[0] ? {1'b0, a_q} : '0);

	// Divide step: shift in one dividend bit, subtract on fit
	assign rem_sh = {rem_q[DRW-2:0], p_q[PW-1]};
	assign gap_ext = {1'b0, gap_q};
	assign rem_ge = rem_sh >= gap_ext;

	// Interpolated voltage
	assign v_apply = sign_q
		? ({prev_v_q[VW-1], prev_v_q[VW-1], prev_v_q} - {1'b0, p_q[MAW-1:0]})
		: ({prev_v_q[VW-1], prev_v_q[VW-1], prev_v_q} + {1'b0, p_q[MAW-1:0]});

	// Halve and saturate the integral
	assign half = p_q[PW-1:1];
	assign sat_neg = sign_q && (half != '0);
	assign sat_over = (half[PW-2:RW] != '0)
		|| (sat_neg ? (half[RW-1] && (half[RW-2:0] != '0)) : half[RW-1]);
	always_comb begin
		if (sat_over) begin
			sat_lo = sat_neg ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
		end else begin
			sat_lo = half[RW-1:0];
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (cmd.cap_item) begin
			ta_q <= time_a;
			tb_q <= time_b;
			t_q <= time_a;
		end
		if (cmd.set_tb) begin
			t_q <= tb_q;
		end
		if (cmd.cap_prev) begin
			prev_t_q <= rd_t;
			prev_v_q <= rd_v;
		end
		if (cmd.cap_hi) begin
			t1_q <= rd_t;
			v1_q <= rd_v;
		end
		if (cmd.calc_diff) begin
			gap_q <= {t1_q[TW-1], t1_q} - {prev_t_q[TW-1], prev_t_q};
			dv_q <= {v1_q[VW-1], v1_q} - {prev_v_q[VW-1], prev_v_q};
			dt_q <= {t_q[TW-1], t_q} - {prev_t_q[TW-1], prev_t_q};
		end
		if (cmd.calc_isum) begin
			dv_q <= {va_q[VW-1], va_q} + {v_q[VW-1], v_q};
			dt_q <= {tb_q[TW-1], tb_q} - {ta_q[TW-1], ta_q};
		end
		if (cmd.load_mul) begin
			a_q <= mag_a(dv_q);
			p_q <= {{MAW{1'b0}}, mag_b(dt_q)};
			sign_q <= dv_q[MAW-1] ^ dt_q[MBW-1];
			cnt_q <= MUL_LAST;
		end
		if (cmd.step_mul) begin
			p_q <= {mul_hi, p_q[MBW-1:1]};
			cnt_q <= cnt_q - CNTW'(1);
		end
		if (cmd.load_div) begin
			rem_q <= '0;
			cnt_q <= DIV_LAST;
		end
		if (cmd.step_div) begin
			rem_q <= rem_ge ? (rem_sh - gap_ext) : rem_sh;
			p_q <= {p_q[PW-2:0], rem_ge};
			cnt_q <= cnt_q - CNTW'(1);
		end
		if (cmd.v_load) begin
			case (cmd.v_sel)
				VS_RDATA: v_q <= rd_v;
				VS_PREV:  v_q <= prev_v_q;
				VS_APPLY: v_q <= v_apply[VW-1:0];
				default:  v_q <= rd_v;
			endcase
		end
		if (cmd.save_va) begin
			va_q <= v_q;
		end
		if (cmd.calc_sat) begin
			ires_q <= sat_neg ? -sat_lo : sat_lo;
			isat_q <= sat_over;
		end
		if (cmd.out_load) begin
			result_value <= cmd.res_integ ? ires_q : {{(RW-VW){v_q[VW-1]}}, v_q};
			gap_error <= err_q;
			saturated <= cmd.res_integ && isat_q;
		end
	end
endmodule

[design/pwl_waveform_interpolator_top.sv]
// Piecewise-linear waveform interpolator. A write word (opcode 0) stores one
// breakpoint and gives no result. An evaluate word (opcode 1) walks the
// breakpoint table one entry a cycle through the table memory's single read
// port. Then, for a time inside the table and a positive gap, it runs a shared
// shift-add multiplier and a restoring divider; a non-positive gap gives the
// lower breakpoint's voltage and sets gap_error.
// An integrate word (opcode 2) runs two evaluations back to back and one more
// pass of the multiplier.
// One word is worked on at a time; a finished result waits in the output
// register while the next word is accepted. The table has no reset; read only
// entries that were written. The user must write point_count only while idle;
// the block itself does not enforce it.
module pwl_waveform_interpolator_top #(
	parameter int MAX_POINTS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	pwi_in_if.sink     in_ch,
	pwi_out_if.source  out_ch,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata
);
	import pwi_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	pwi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_opcode (in_ch.opcode),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pwi_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.point_index  (in_ch.point_index),
		.time_a       (in_ch.time_a),
		.time_b       (in_ch.time_b),
		.volt_in      (in_ch.volt_in),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_value (out_ch.result_value),
		.gap_error    (out_ch.gap_error),
		.saturated    (out_ch.saturated)
	);

	// Never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_ch.valid || out_ch.ready))
		else $error("result register loaded while occupied");

	// Go busy after taking an evaluate or integrate word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready
			&& (in_ch.opcode == OP_EVAL || in_ch.opcode == OP_INTEG))
		|=> !in_ch.ready)
		else $error("ready while a word is in progress");

	// Divide only by a positive gap
	a_div_gap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step_div |-> !stat.gap_bad)
		else $error("divide with non-positive gap");
endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import pwi_pkg::*;

	localparam int TABLE_DEPTH  = 64;
	localparam int SETTLE_CYC   = 700;
	localparam int STALL_LIMIT  = 6000;

	typedef struct {
		logic signed [63:0] value;
		logic               gap;
		logic               sat;
	} wave_result_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [6:0] cfg_wdata;

	pwi_in_if  in_ch ();
	pwi_out_if out_ch ();

	pwl_waveform_interpolator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow copy of the breakpoint table and the point count
	logic signed [39:0] bp_time [TABLE_DEPTH];
	logic signed [31:0] bp_volt [TABLE_DEPTH];
	int unsigned        active_points;

	wave_result_t pending_results [$];
	int unsigned  mismatch_count;
	int unsigned  idle_cycles;
	int unsigned  burst_left;

	// Clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Voltage of the waveform at time t
	function automatic logic signed [63:0] wave_volt(input logic signed [39:0] t,
			inout logic gap_flag);
		logic signed [63:0] t0, v0, gap, dv, dt;
		logic [127:0]       mdv, mdt, quot;
		int unsigned        last;
		last = active_points - 1;
		if (t < bp_time[0])
			return 64'(bp_volt[0]);
		if (t >= bp_time[last])
			return 64'(bp_volt[last]);
		for (int i = 1; i < active_points; i++) begin
			if (t < bp_time[i]) begin
				t0  = 64'(bp_time[i-1]);
				v0  = 64'(bp_volt[i-1]);
				gap = 64'(bp_time[i]) - t0;
				dv  = 64'(bp_volt[i]) - v0;
				dt  = 64'(t) - t0;
				if (gap <= 0) begin
					gap_flag = 1'b1;
					return v0;
				end
				mdv  = {64'd0, (dv < 0) ? 64'(-dv) : 64'(dv)};
				mdt  = {64'd0, (dt < 0) ? 64'(-dt) : 64'(dt)};
				quot = (mdv * mdt) / {64'd0, gap};
				if ((dv < 0) != (dt < 0))
					return v0 - $signed(quot[63:0]);
				return v0 + $signed(quot[63:0]);
			end
		end
		return 64'(bp_volt[last]);
	endfunction

	// Work out the result of one accepted word, update the shadow table on writes
	function automatic void predict_word(input op_t op, input logic [5:0] idx,
			input logic signed [39:0] ta, input logic signed [39:0] tb,
			input logic signed [31:0] vin);
		wave_result_t       r;
		logic signed [63:0] vsum, span;
		logic [127:0]       prod, lim;
		logic               neg;
		r.gap = 1'b0;
		r.sat = 1'b0;
		case (op)
			OP_WRITE: begin
				bp_time[idx] = ta;
				bp_volt[idx] = vin;
			end
			OP_EVAL: begin
				r.value = wave_volt(ta, r.gap);
				pending_results.push_back(r);
			end
			OP_INTEG: begin
				vsum = wave_volt(ta, r.gap);
				vsum = vsum + wave_volt(tb, r.gap);
				span = 64'(tb) - 64'(ta);
				prod = {64'd0, (vsum < 0) ? 64'(-vsum) : 64'(vsum)}
					* {64'd0, (span < 0) ? 64'(-span) : 64'(span)};
				prod = prod >> 1;
				neg  = ((vsum < 0) != (span < 0)) && (prod != 0);
				lim  = neg ? (128'd1 << 63) : ((128'd1 << 63) - 1);
				if (prod > lim) begin
					prod  = lim;
					r.sat = 1'b1;
				end
				r.value = neg ? -$signed(prod[63:0]) : $signed(prod[63:0]);
				pending_results.push_back(r);
			end
			default: ;
		endcase
	endfunction

	// Send one word, often with a random gap before a new burst
	task automatic send_word(input op_t op, input logic [5:0] idx,
			input logic signed [39:0] ta, input logic signed [39:0] tb,
			input logic signed [31:0] vin);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 2) != 0) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
		end
		burst_left--;
		in_ch.valid       <= 1'b1;
		in_ch.opcode      <= op;
		in_ch.point_index <= idx;
		in_ch.time_a      <= ta;
		in_ch.time_b      <= tb;
		in_ch.volt_in     <= vin;
		do
			@(posedge clk);
		while (!(in_ch.valid && in_ch.ready));
		predict_word(op, idx, ta, tb, vin);
	endtask

	// Drain the block, then write the point count
	task automatic set_point_count(input logic [6:0] cnt);
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= cnt;
		@(posedge clk);
		cfg_we <= 1'b0;
		active_points = (cnt == 0) ? 1 : (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
	endtask

	function automatic logic signed [39:0] rand_time();
		return 40'({$urandom, $urandom});
	endfunction

	// Time near the populated span, mostly inside it
	function automatic logic signed [39:0] near_time();
		int unsigned j;
		j = $urandom_range(0, active_points - 1);
		if ($urandom_range(0, 9) == 0)
			return rand_time();
		return bp_time[j] + 40'($signed($urandom_range(0, 32'h3fff_ffff)) - 32'sh1fff_ffff)
			* 40'($urandom_range(1, 8));
	endfunction

	// Fill every slot in ascending time, volts at the rails
	task automatic test_full_table();
		logic signed [39:0] t;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			t = -40'sh80_0000_0000 + 40'(i) * 40'd17452565520;
			send_word(OP_WRITE, 6'(i), t, rand_time(),
				(i % 2 == 0) ? 32'sh7fff_ffff : 32'sh8000_0000);
		end
	endtask

	// Field extremes, the evaluate, integrate and no-op opcodes, clamping of the point count
	task automatic test_directed();
		set_point_count(7'd64);
		send_word(OP_EVAL, 6'd0, -40'sh80_0000_0000, 40'sd0, 32'sd0);
		send_word(OP_EVAL, 6'd63, 40'sh7f_ffff_ffff, 40'sd0, 32'sd0);
		send_word(OP_EVAL, 6'd0, bp_time[10], 40'sd0, 32'sd0);
		send_word(OP_EVAL, 6'd0, bp_time[10] + 40'sd12345, 40'sd0, 32'sd0);
		send_word(OP_EVAL, 6'd0, bp_time[62] + 40'sd1, 40'sd0, 32'sd0);
		// full-range trapezoid; reversed one flips the sign
		send_word(OP_INTEG, 6'd0, -40'sh80_0000_0000, 40'sh7f_ffff_ffff, 32'sd0);
		send_word(OP_INTEG, 6'd0, 40'sh7f_ffff_ffff, -40'sh80_0000_0000, 32'sd0);
		send_word(OP_INTEG, 6'd0, bp_time[3], bp_time[3] + 40'sd999, 32'sd0);
		send_word(OP_INTEG, 6'd0, bp_time[4] + 40'sd999, bp_time[4], 32'sd0);
		send_word(OP_INTEG, 6'd0, bp_time[7], bp_time[7], 32'sd0);
		send_word(OP_NONE, 6'h3f, 40'sh7f_ffff_ffff, -40'sd1, 32'shffff_ffff);
		send_word(OP_EVAL, 6'd0, bp_time[20] - 40'sd1, 40'sd0, 32'sd0);
		set_point_count(7'd0);
		send_word(OP_EVAL, 6'd0, bp_time[30], 40'sd0, 32'sd0);
		send_word(OP_INTEG, 6'd0, -40'sd5, 40'sd5, 32'sd0);
		set_point_count(7'h7f);
		send_word(OP_EVAL, 6'd0, bp_time[40] + 40'sd77, 40'sd0, 32'sd0);
		set_point_count(7'd65);
		send_word(OP_INTEG, 6'd0, bp_time[1] + 40'sd3, bp_time[60] - 40'sd3, 32'sd0);
		set_point_count(7'd1);
		send_word(OP_EVAL, 6'd0, bp_time[0] - 40'sd1, 40'sd0, 32'sd0);
		send_word(OP_INTEG, 6'd0, bp_time[0], bp_time[50], 32'sd0);
	endtask

	// Phases of random traffic over fresh ascending tables
	task automatic test_random_traffic();
		logic signed [39:0] t, step;
		int unsigned        cnt, pick;
		logic [5:0]         slot;
		for (int ph = 0; ph < 6; ph++) begin
			cnt = (ph == 0) ? 64 : (ph == 1) ? 2 : $urandom_range(1, 64);
			set_point_count(7'(cnt));
			t = -40'sh80_0000_0000 + 40'($urandom);
			for (int i = 0; i < cnt; i++) begin
				step = ($urandom_range(0, 5) == 0) ? 40'sd1
					: 40'({$urandom_range(0, 1), $urandom});
				send_word(OP_WRITE, 6'(i), t, rand_time(), $signed($urandom));
				t = t + step;
			end
			for (int k = 0; k < 45; k++) begin
				pick = $urandom_range(0, 99);
				slot = 6'($urandom_range(0, 63));
				if (pick < 15)
					// new volt at the same time keeps the order
					send_word(OP_WRITE, slot, bp_time[slot], rand_time(),
						$signed($urandom));
				else if (pick < 20)
					send_word(OP_WRITE, slot, rand_time(), rand_time(),
						$signed($urandom));
				else if (pick < 55)
					send_word(OP_EVAL, slot, near_time(), rand_time(),
						$signed($urandom));
				else if (pick < 95)
					send_word(OP_INTEG, slot, near_time(), near_time(),
						$signed($urandom));
				else
					send_word(OP_NONE, slot, rand_time(), rand_time(),
						$signed($urandom));
			end
		end
	endtask

	// Receiver stalls, with stretches of steady ready
	always @(posedge clk) begin
		if (($urandom_range(0, 255) < 64) || (($time / 3000) % 3 == 0))
			out_ch.ready <= 1'b1;
		else
			out_ch.ready <= ($urandom_range(0, 3) == 0);
	end

	// Compare each result word with the oldest expectation
	always @(posedge clk) begin
		wave_result_t exp_r;
		if (out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result word: value %0d", out_ch.result_value);
			end else begin
				exp_r = pending_results.pop_front();
				if (out_ch.result_value !== exp_r.value
						|| out_ch.gap_error !== exp_r.gap
						|| out_ch.saturated !== exp_r.sat) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
							exp_r.value, exp_r.gap, exp_r.sat,
							out_ch.result_value, out_ch.gap_error, out_ch.saturated);
				end
			end
		end
	end

	// Watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = 7'd0;
		in_ch.valid       = 1'b0;
		in_ch.opcode      = OP_NONE;
		in_ch.point_index = 6'd0;
		in_ch.time_a      = 40'sd0;
		in_ch.time_b      = 40'sd0;
		in_ch.volt_in     = 32'sd0;
		out_ch.ready      = 1'b0;
		mismatch_count    = 0;
		idle_cycles       = 0;
		burst_left        = 0;
		active_points     = 1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_full_table();
		test_directed();
		test_random_traffic();

		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
